// ----- hdl/msa_pkg.sv -----
// Shared constants, command and status types for the mesh snake allocator.
package msa_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_DIMS_DEF  = 3;

    localparam int PROCS_W = 13;
    localparam int EXT_W   = 7;
    localparam int DIMS_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;
    localparam int CFG_IW  = 3;
    // numerator of the ceiling division: procs + cores - 1
    localparam int NUM_W   = PROCS_W + 1;

    localparam logic [CFG_IW-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DIMS   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CORES  = 3'd4;

    localparam logic [EXT_W-1:0]  SIZE_RST  = 7'd4;
    localparam logic [DIMS_W-1:0] DIMS_RST  = 2'd3;
    localparam logic [EXT_W-1:0]  CORES_RST = 7'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_SETUP,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_ROOT_NEXT,
        OP_BOX_INIT,
        OP_PROD,
        OP_GROW_INC,
        OP_GROW_NEXT,
        OP_WALK
    } t_op;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_NODE,
        EMIT_ONE,
        EMIT_BIG
    } t_emit;

    typedef struct packed {
        t_op   op;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic k_dims_last;
        logic k_nd_done;
        logic need_zero;
        logic need_one;
        logic need_big;
        logic acc_ok;
        logic box_full;
        logic g_last;
        logic walk_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/msa_dp.sv -----
// Datapath: divider, saturating multiplier, box registers, snake walker, output stage.
module msa_dp
    import msa_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_DIMS  = MAX_DIMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PROCS_W-1:0] i_procs_needed,
    input  logic [EXT_W-1:0]   i_size_x,
    input  logic [EXT_W-1:0]   i_size_y,
    input  logic [EXT_W-1:0]   i_size_z,
    input  logic [DIMS_W-1:0]  i_dims_used,
    input  logic [EXT_W-1:0]   i_cores_per_node,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [IDX_W-1:0]   o_node_index,
    output logic               o_last,
    output logic               o_too_big
);

    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int MB_W   = (NW > EXT_W) ? NW : EXT_W;
    localparam int PW     = NW + MB_W;
    localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ND_W   = $clog2(MAX_DIMS + 1);
    localparam int DCNT_W = $clog2(NUM_W);

    function automatic logic [EXT_W-1:0] f_nz(input logic [EXT_W-1:0] v);
        return (v == '0) ? EXT_W'(1) : v;
    endfunction

    // divider
    logic [NUM_W-1:0]  r_quo;
    logic [EXT_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    // shared multiplier accumulator and step counter
    logic [NW-1:0]     r_acc;
    logic [ND_W-1:0]   r_k;
    logic [NW-1:0]     r_c;
    logic [IDX_W-1:0]  r_sacc;
    logic [IDX_W-1:0]  r_stride [MAX_DIMS];
    logic [EXT_W-1:0]  r_box    [MAX_DIMS];
    logic [DI_W-1:0]   r_g;
    // snake walker
    logic [EXT_W-1:0]  r_loc    [MAX_DIMS];
    logic [MAX_DIMS-1:0] r_fwd;
    logic [IDX_W-1:0]  r_idx;
    logic [NW-1:0]     r_cnt;
    // output stage
    logic              r_ov;
    logic [IDX_W-1:0]  r_node;
    logic              r_last;
    logic              r_big;

    logic [EXT_W-1:0]  cpn;
    logic [EXT_W-1:0]  ext [MAX_DIMS];
    logic [ND_W-1:0]   nd;
    logic [DIMS_W:0]   nd_raw;
    logic [DI_W-1:0]   ki;
    logic [NW-1:0]     need_n;
    logic [EXT_W:0]    div_t;
    logic              div_ge;
    logic [MB_W-1:0]   mul_b;
    logic [PW-1:0]     mul_p;
    logic [NW-1:0]     acc_sat;
    logic [2*EXT_W-1:0] smul;
    logic              walk_last;
    logic              out_free;

    logic [DI_W-1:0]     ld;
    logic [MAX_DIMS-1:0] at_end;
    logic [MAX_DIMS-1:0] n_fwd;
    logic                going;
    int                  cur;
    logic                mv_found;
    logic [DI_W-1:0]     mv_dim;

    always_comb begin
        logic [EXT_W-1:0] sz;
        cpn = f_nz(i_cores_per_node);
        nd_raw = (i_dims_used == '0) ? (DIMS_W + 1)'(1) : {1'b0, i_dims_used};
        if (int'(nd_raw) > MAX_DIMS) begin
            nd = ND_W'(MAX_DIMS);
        end else begin
            nd = ND_W'(nd_raw);
        end
        for (int i = 0; i < MAX_DIMS; i++) begin
            sz = EXT_W'(1);
            if (i == 0) begin
                sz = f_nz(i_size_x);
            end else if (i == 1) begin
                sz = f_nz(i_size_y);
            end else if (i == 2) begin
                sz = f_nz(i_size_z);
            end
            ext[i] = (i < int'(nd)) ? sz : EXT_W'(1);
        end
    end

    assign ki     = r_k[DI_W-1:0];
    assign need_n = r_quo[NW-1:0];

    assign div_t  = {r_rem, r_quo[NUM_W-1]};
    assign div_ge = (div_t >= {1'b0, cpn});

    always_comb begin
        case (i_cmd.op)
            OP_SETUP:     mul_b = MB_W'(ext[ki]);
            OP_ROOT_STEP: mul_b = MB_W'(r_c);
            OP_PROD:      mul_b = MB_W'(r_box[ki]);
            default:      mul_b = MB_W'(1);
        endcase
    end

    // saturate at the node limit: only comparisons against a need up to it matter
    assign mul_p   = PW'(r_acc) * PW'(mul_b);
    assign acc_sat = (mul_p > PW'(MAX_NODES)) ? NW'(MAX_NODES) : mul_p[NW-1:0];
    assign smul    = (2*EXT_W)'(r_sacc) * (2*EXT_W)'(ext[ki]);

    assign walk_last = (r_cnt == need_n - NW'(1));
    assign out_free  = !r_ov || i_out_ready;

    // snake step: flip directions at ends, then move the dim where the carry stops
    always_comb begin
        ld = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (r_box[i] != EXT_W'(1)) begin
                ld = DI_W'(i);
            end
            at_end[i] = r_fwd[i] ? (r_loc[i] == r_box[i] - EXT_W'(1)) : (r_loc[i] == '0);
        end
        going = 1'b1;
        cur   = 0;
        n_fwd = r_fwd;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (going) begin
                if (at_end[i]) begin
                    n_fwd[i] = !r_fwd[i];
                    if (i == int'(ld)) begin
                        going = 1'b0;
                        cur   = i;
                    end else begin
                        cur = i + 1;
                    end
                end else begin
                    going = 1'b0;
                    cur   = i;
                end
            end
        end
        mv_found = 1'b0;
        mv_dim   = '0;
        for (int i = MAX_DIMS - 1; i >= 0; i--) begin
            if (!mv_found && i <= cur && r_box[i] != EXT_W'(1)) begin
                mv_found = 1'b1;
                mv_dim   = DI_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_quo  <= NUM_W'(i_procs_needed) + NUM_W'(cpn) - NUM_W'(1);
                r_rem  <= '0;
                r_dcnt <= '0;
                r_acc  <= NW'(1);
                r_k    <= '0;
                r_sacc <= IDX_W'(1);
                r_g    <= '0;
                r_fwd  <= '1;
                r_idx  <= '0;
                r_cnt  <= '0;
                for (int i = 0; i < MAX_DIMS; i++) begin
                    r_loc[i] <= '0;
                end
            end
            OP_DIV: begin
                r_rem  <= div_ge ? EXT_W'(div_t - {1'b0, cpn}) : div_t[EXT_W-1:0];
                r_quo  <= {r_quo[NUM_W-2:0], div_ge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            OP_SETUP: begin
                r_acc        <= acc_sat;
                r_stride[ki] <= r_sacc;
                r_sacc       <= smul[IDX_W-1:0];
                r_k          <= r_k + ND_W'(1);
            end
            OP_ROOT_INIT: begin
                r_c   <= (nd == ND_W'(1)) ? need_n : NW'(2);
                r_acc <= NW'(1);
                r_k   <= '0;
            end
            OP_ROOT_STEP: begin
                r_acc <= acc_sat;
                r_k   <= r_k + ND_W'(1);
            end
            OP_ROOT_NEXT: begin
                r_c   <= r_c + NW'(1);
                r_acc <= NW'(1);
                r_k   <= '0;
            end
            OP_BOX_INIT: begin
                for (int i = 0; i < MAX_DIMS; i++) begin
                    if (i < int'(nd) && MB_W'(r_c) < MB_W'(ext[i])) begin
                        r_box[i] <= EXT_W'(r_c);
                    end else begin
                        r_box[i] <= ext[i];
                    end
                end
                r_acc <= NW'(1);
                r_k   <= '0;
            end
            OP_PROD: begin
                r_acc <= acc_sat;
                r_k   <= r_k + ND_W'(1);
            end
            OP_GROW_INC: begin
                r_box[r_g] <= r_box[r_g] + EXT_W'(1);
                r_acc      <= NW'(1);
                r_k        <= '0;
            end
            OP_GROW_NEXT: begin
                r_g <= r_g + DI_W'(1);
            end
            OP_WALK: begin
                r_fwd <= n_fwd;
                r_cnt <= r_cnt + NW'(1);
                if (mv_found) begin
                    if (n_fwd[mv_dim]) begin
                        r_loc[mv_dim] <= r_loc[mv_dim] + EXT_W'(1);
                        r_idx         <= r_idx + r_stride[mv_dim];
                    end else if (r_loc[mv_dim] != '0) begin
                        r_loc[mv_dim] <= r_loc[mv_dim] - EXT_W'(1);
                        r_idx         <= r_idx - r_stride[mv_dim];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output stage: a beat waits here while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        case (i_cmd.emit)
            EMIT_NODE: begin
                r_node <= r_idx;
                r_last <= walk_last;
                r_big  <= 1'b0;
            end
            EMIT_ONE: begin
                r_node <= '0;
                r_last <= 1'b1;
                r_big  <= 1'b0;
            end
            EMIT_BIG: begin
                r_node <= '0;
                r_last <= 1'b1;
                r_big  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_ov;
    assign o_node_index = r_node;
    assign o_last       = r_last;
    assign o_too_big    = r_big;

    assign o_stat.div_last    = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_stat.k_dims_last = (r_k == ND_W'(MAX_DIMS - 1));
    assign o_stat.k_nd_done   = (r_k == nd);
    assign o_stat.need_zero   = (r_quo == '0);
    assign o_stat.need_one    = (r_quo == NUM_W'(1));
    assign o_stat.need_big    = (r_quo > NUM_W'(r_acc));
    assign o_stat.acc_ok      = (NUM_W'(r_acc) >= r_quo);
    assign o_stat.box_full    = (r_box[r_g] >= ext[r_g]);
    assign o_stat.g_last      = (r_g == DI_W'(MAX_DIMS - 1));
    assign o_stat.walk_last   = walk_last;
    assign o_stat.out_free    = out_free;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != EMIT_NONE) |-> out_free)
        else $error("beat loaded while output stage is occupied");
    a_big_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_big) |-> (r_last && r_node == '0))
        else $error("oversize beat is not a single last beat at node zero");
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WALK) |-> (r_cnt < need_n))
        else $error("walk runs past the node count");
    a_walk_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WALK) |-> (r_loc[0] < r_box[0]))
        else $error("snake position left the box");
`endif

endmodule

// ----- hdl/msa_ctrl.sv -----
// Controller: sequences division, mesh setup, root search, box growth and the walk.
module msa_ctrl
    import msa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_CHECK,
        S_ROOT,
        S_PROD,
        S_GROW,
        S_WALK,
        S_ONE,
        S_BIG
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.emit = EMIT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                if (i_stat.k_dims_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.need_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.need_big) begin
                    n_state = S_BIG;
                end else if (i_stat.need_one) begin
                    n_state = S_ONE;
                end else begin
                    o_cmd.op = OP_ROOT_INIT;
                    n_state  = S_ROOT;
                end
            end
            S_ROOT: begin
                if (!i_stat.k_nd_done) begin
                    o_cmd.op = OP_ROOT_STEP;
                end else if (i_stat.acc_ok) begin
                    o_cmd.op = OP_BOX_INIT;
                    n_state  = S_PROD;
                end else begin
                    o_cmd.op = OP_ROOT_NEXT;
                end
            end
            S_PROD: begin
                o_cmd.op = OP_PROD;
                if (i_stat.k_dims_last) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (i_stat.acc_ok) begin
                    n_state = S_WALK;
                end else if (!i_stat.box_full) begin
                    o_cmd.op = OP_GROW_INC;
                    n_state  = S_PROD;
                end else if (i_stat.g_last) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.op = OP_GROW_NEXT;
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = OP_WALK;
                    o_cmd.emit = EMIT_NODE;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_ONE;
                    n_state    = S_IDLE;
                end
            end
            S_BIG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = EMIT_BIG;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hdl/mesh_snake_allocator.sv -----
// Mesh snake allocator: configuration registers, controller and datapath.
//
// Input channel (i_in_valid / o_in_ready) carries one beat per job: the
// processor count. Output channel (o_out_valid / i_out_ready) carries one
// beat per allocated node: its linear mesh index and a last flag, or a
// single beat with too_big set when the job does not fit the mesh.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Index 0..2 set the extents, 3 the dimension
// count, 4 the cores per node. One job at a time. A job runs through
// accept, ceiling division, mesh product and strides, range check, root
// candidates (one shared multiplier), box product and fit check, box
// growth step by step and past each full dimension, then the node walk;
// the node walk usually dominates. A zero count gives no beat. o_in_ready
// is high whenever the controller is idle, also while the final beat
// still waits in the output register. A stalled receiver holds the walk
// one node at a time; nothing is dropped. Reset returns to idle, empties
// the output register and restores the default configuration.
module mesh_snake_allocator
    import msa_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_DIMS  = MAX_DIMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PROCS_W-1:0] i_procs_needed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [IDX_W-1:0]   o_node_index,
    output logic               o_last,
    output logic               o_too_big,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [EXT_W-1:0]  r_size_x;
    logic [EXT_W-1:0]  r_size_y;
    logic [EXT_W-1:0]  r_size_z;
    logic [DIMS_W-1:0] r_dims_used;
    logic [EXT_W-1:0]  r_cores_per_node;

    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x         <= SIZE_RST;
            r_size_y         <= SIZE_RST;
            r_size_z         <= SIZE_RST;
            r_dims_used      <= DIMS_RST;
            r_cores_per_node <= CORES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x         <= i_cfg_data[EXT_W-1:0];
                CFG_SIZE_Y: r_size_y         <= i_cfg_data[EXT_W-1:0];
                CFG_SIZE_Z: r_size_z         <= i_cfg_data[EXT_W-1:0];
                CFG_DIMS:   r_dims_used      <= i_cfg_data[DIMS_W-1:0];
                CFG_CORES:  r_cores_per_node <= i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    msa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    msa_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_DIMS  (MAX_DIMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_procs_needed   (i_procs_needed),
        .i_size_x         (r_size_x),
        .i_size_y         (r_size_y),
        .i_size_z         (r_size_z),
        .i_dims_used      (r_dims_used),
        .i_cores_per_node (r_cores_per_node),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_node_index     (o_node_index),
        .o_last           (o_last),
        .o_too_big        (o_too_big)
    );

endmodule

// ----- tb/mesh_snake_allocator_tb.sv -----
// Testbench for mesh_snake_allocator: directed and random jobs checked against a node-plan scoreboard.
module mesh_snake_allocator_tb;
    import msa_pkg::*;

    localparam int SETTLE_CYCLES = 600;
    localparam int WATCHDOG      = 5000;
    localparam int JOBS_PER_MESH = 18;
    localparam int PROCS_MAX     = (1 << PROCS_W) - 1;

    localparam logic [CFG_IW-1:0] REG_ORDER [5] =
        '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_DIMS, CFG_CORES};

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             last;
        logic             big;
    } node_beat_t;

    class alloc_scoreboard;
        int unsigned ext_reg [MAX_DIMS_DEF];
        int unsigned dims_reg;
        int unsigned cores_reg;
        node_beat_t  nodes_due [$];
        int          errors;

        function new();
            ext_reg   = '{SIZE_RST, SIZE_RST, SIZE_RST};
            dims_reg  = DIMS_RST;
            cores_reg = CORES_RST;
            errors    = 0;
        endfunction

        function int unsigned at_least_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SIZE_X: ext_reg[0] = data;
                CFG_SIZE_Y: ext_reg[1] = data;
                CFG_SIZE_Z: ext_reg[2] = data;
                CFG_DIMS:   dims_reg  = data[DIMS_W-1:0];
                CFG_CORES:  cores_reg = data;
                default: ;
            endcase
        endfunction

        function int unsigned dims();
            return at_least_one(dims_reg);
        endfunction

        function int unsigned cores();
            return at_least_one(cores_reg);
        endfunction

        function int unsigned extent(int i);
            return (i < dims()) ? at_least_one(ext_reg[i]) : 1;
        endfunction

        // usable node count, saturated at the node limit
        function int unsigned mesh_cap();
            int unsigned tot;
            tot = 1;
            for (int i = 0; i < MAX_DIMS_DEF; i++) begin
                tot = tot * extent(i);
                if (tot > MAX_NODES_DEF) tot = MAX_NODES_DEF + 1;
            end
            return (tot > MAX_NODES_DEF) ? MAX_NODES_DEF : tot;
        endfunction

        function void push_node(int unsigned idx, bit last, bit big);
            node_beat_t b;
            b.node = idx[IDX_W-1:0];
            b.last = last;
            b.big  = big;
            nodes_due.push_back(b);
        endfunction

        // plan the node list of one accepted job
        function void note_job(logic [PROCS_W-1:0] procs);
            int unsigned ext [MAX_DIMS_DEF];
            int unsigned box [MAX_DIMS_DEF];
            int unsigned loc [MAX_DIMS_DEF];
            bit          fwd [MAX_DIMS_DEF];
            int unsigned nd, cpn, need, cap, c, fill, idx;
            longint unsigned pw;
            int          cur, top;
            nd   = dims();
            cpn  = cores();
            need = (int'(procs) + cpn - 1) / cpn;
            cap  = mesh_cap();
            for (int i = 0; i < MAX_DIMS_DEF; i++) ext[i] = extent(i);
            if (need == 0) return;
            if (need > cap) begin
                push_node(0, 1'b1, 1'b1);
                return;
            end
            if (need == 1) begin
                push_node(0, 1'b1, 1'b0);
                return;
            end
            // smallest c with c to the power nd at least need
            c  = 0;
            pw = 0;
            while (pw < need) begin
                c++;
                pw = 1;
                for (int i = 0; i < nd; i++) pw = pw * c;
            end
            fill = 1;
            for (int i = 0; i < MAX_DIMS_DEF; i++) begin
                box[i] = (i < nd && c < ext[i]) ? c : ext[i];
                fill   = fill * box[i];
            end
            for (int i = 0; i < MAX_DIMS_DEF && fill < need; i++) begin
                while (box[i] < ext[i] && fill < need) begin
                    fill = fill / box[i] * (box[i] + 1);
                    box[i]++;
                end
            end
            for (int i = 0; i < MAX_DIMS_DEF; i++) begin
                loc[i] = 0;
                fwd[i] = 1'b1;
            end
            top = MAX_DIMS_DEF - 1;
            while (top > 0 && box[top] == 1) top--;
            for (int unsigned n = 0; n < need; n++) begin
                idx = loc[0] + loc[1] * ext[0] + loc[2] * ext[0] * ext[1];
                push_node(idx, n + 1 == need, 1'b0);
                if (n + 1 < need) begin
                    // flip direction on each exhausted dimension, carry upward
                    cur = 0;
                    while ((fwd[cur] && loc[cur] == box[cur] - 1) ||
                           (!fwd[cur] && loc[cur] == 0)) begin
                        fwd[cur] = !fwd[cur];
                        if (cur != top) cur++;
                        else break;
                    end
                    while (cur >= 0) begin
                        if (box[cur] != 1) begin
                            if (fwd[cur]) loc[cur]++;
                            else if (loc[cur] > 0) loc[cur]--;
                            break;
                        end
                        cur--;
                    end
                end
            end
        endfunction

        function void check_node(logic [IDX_W-1:0] node, logic last, logic big);
            node_beat_t want;
            if (nodes_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: node %0d last %b too_big %b", node, last, big);
                return;
            end
            want = nodes_due.pop_front();
            if (node !== want.node || last !== want.last || big !== want.big) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: node %0d last %b too_big %b, expected %0d %b %b",
                             node, last, big, want.node, want.last, want.big);
            end
        endfunction

        function int pending();
            return nodes_due.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [PROCS_W-1:0] i_procs_needed;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [IDX_W-1:0]   o_node_index;
    logic               o_last;
    logic               o_too_big;
    logic               i_cfg_we;
    logic [CFG_IW-1:0]  i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    alloc_scoreboard sb = new();
    bit  idling    = 1'b1;
    bit  in_took   = 1'b0;
    int  quiet     = 0;
    int  stall_left = 0;

    int unsigned dir_list [15] =
        '{0, 1, 2, 3, 5, 8, 9, 17, 27, 28, 63, 64, 65, 4096, PROCS_MAX};

    // x, y, z, dims, cores
    logic [CFG_W-1:0] mesh_set [9][5] = '{
        '{1,   1,   1,   1,   1},
        '{64,  1,   1,   1,   1},
        '{0,   0,   0,   0,   0},
        '{127, 127, 127, 127, 127},
        '{100, 2,   9,   2,   1},
        '{8,   8,   1,   2,   4},
        '{3,   5,   7,   3,   2},
        '{5,   6,   7,   1,   3},
        '{2,   3,   4,   3,   1}
    };

    mesh_snake_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_procs_needed (i_procs_needed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_node_index   (o_node_index),
        .o_last         (o_last),
        .o_too_big      (o_too_big),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            in_took <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) sb.note_job(i_procs_needed);
            if (o_out_valid && i_out_ready) sb.check_node(o_node_index, o_last, o_too_big);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet <= 0;
            end else if (quiet >= WATCHDOG) begin
                $display("FAIL mesh_snake_allocator");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_job(input logic [PROCS_W-1:0] procs);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_procs_needed <= procs;
        do @(negedge i_clk); while (!in_took);
    endtask

    // drain all beats, then give a zero-node job time to retire
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_mesh(input logic [CFG_W-1:0] vals [5]);
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 5; k++) begin
            i_cfg_index <= REG_ORDER[k];
            i_cfg_data  <= vals[k];
            sb.write_reg(REG_ORDER[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PROCS_W-1:0] pick_procs();
        int unsigned span, cpn;
        cpn  = sb.cores();
        span = sb.mesh_cap() * cpn;
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return PROCS_W'($urandom_range(0, PROCS_MAX));
            2:       return PROCS_W'(span + 1);
            3, 4, 5: return PROCS_W'($urandom_range(1, (cpn * 4 < span) ? cpn * 4 : span));
            default: return PROCS_W'($urandom_range(1, span));
        endcase
    endfunction

    task automatic run_jobs(input int n);
        repeat (n) send_job(pick_procs());
    endtask

    initial begin
        logic [CFG_W-1:0] row [5];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_procs_needed = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_SIZE_X;
        i_cfg_data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset mesh: 4x4x4, one core per node
        foreach (dir_list[k]) send_job(PROCS_W'(dir_list[k]));

        for (int s = 0; s < 9; s++) begin
            settle();
            load_mesh(mesh_set[s]);
            run_jobs(JOBS_PER_MESH);
        end

        for (int s = 0; s < 4; s++) begin
            settle();
            row[0] = CFG_W'($urandom_range(1, 8));
            row[1] = CFG_W'($urandom_range(1, 8));
            row[2] = CFG_W'($urandom_range(1, 8));
            row[3] = CFG_W'($urandom_range(0, 3));
            row[4] = CFG_W'($urandom_range(1, 8));
            if (s == 3) idling = 1'b0;
            load_mesh(row);
            run_jobs(JOBS_PER_MESH);
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS mesh_snake_allocator");
        end else begin
            $display("FAIL mesh_snake_allocator");
        end
        $finish;
    end

endmodule
